[rtl/core/bdk_pkg.sv]
// bdk_pkg: types, widths, register codes and helpers for the background difference key
// no dependencies
package bdk_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int DIFF_W    = 18;
	localparam int INV_W     = 24;
	localparam int SUM_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int PROD_W    = DIFF_W + INV_W;
	localparam int RND_W     = PROD_W + 1;
	localparam int RAMP_W    = RND_W - 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SAMPLE_MAX   = 3'd0;
	localparam cfg_idx_t CFG_MATCH_LIMIT  = 3'd1;
	localparam cfg_idx_t CFG_BLEND_ON     = 3'd2;
	localparam cfg_idx_t CFG_INV_BLEND    = 3'd3;
	localparam cfg_idx_t CFG_CHANGE_LIMIT = 3'd4;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_max;
		logic [DIFF_W-1:0]   match_limit;
		logic                blend_on;
		logic [INV_W-1:0]    inv_blend;
		logic [SUM_W-1:0]    change_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sample_max:   16'd255,
		match_limit:  18'd76,
		blend_on:     1'b0,
		inv_blend:    24'd256,
		change_limit: 48'd0
	};

	// one classified pixel on its way from front to back
	typedef struct packed {
		logic [DIFF_W-1:0] diff;
		logic              last;
		logic              replace;
		logic [SUM_W-1:0]  frame_sum;
	} work_t;

	function automatic logic [SAMPLE_W-1:0] absdiff(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

[rtl/core/bdk_in_if.sv]
// bdk_in_if: pixel input channel, valid/ready with current and background samples
// depends on bdk_pkg
interface bdk_in_if;
	logic                          valid;
	logic                          ready;
	logic [bdk_pkg::SAMPLE_W-1:0]  cur_luma;
	logic [bdk_pkg::SAMPLE_W-1:0]  cur_cb;
	logic [bdk_pkg::SAMPLE_W-1:0]  cur_cr;
	logic [bdk_pkg::SAMPLE_W-1:0]  bg_luma;
	logic [bdk_pkg::SAMPLE_W-1:0]  bg_cb;
	logic [bdk_pkg::SAMPLE_W-1:0]  bg_cr;
	logic                          frame_last;

	modport source(output valid, cur_luma, cur_cb, cur_cr, bg_luma, bg_cb, bg_cr,
		frame_last, input ready);
	modport sink(input valid, cur_luma, cur_cb, cur_cr, bg_luma, bg_cb, bg_cr,
		frame_last, output ready);
endinterface

[rtl/core/bdk_out_if.sv]
// bdk_out_if: key output channel, valid/ready with alpha and frame status
// depends on bdk_pkg
interface bdk_out_if;
	logic                         valid;
	logic                         ready;
	logic [bdk_pkg::SAMPLE_W-1:0] alpha;
	logic                         frame_done;
	logic                         replace_background;
	logic [bdk_pkg::SUM_W-1:0]    frame_sum;

	modport source(output valid, alpha, frame_done, replace_background, frame_sum,
		input ready);
	modport sink(input valid, alpha, frame_done, replace_background, frame_sum,
		output ready);
endinterface

[rtl/core/bdk_front.sv]
// bdk_front: accepts pixels, forms the difference, keeps the frame sum and decides replacement
// depends on bdk_pkg and bdk_in_if
module bdk_front (
	input  logic            clk,
	input  logic            arst_n,
	input  bdk_pkg::cfg_t   cfg,
	bdk_in_if.sink          pix,
	output logic            push,
	output bdk_pkg::work_t  push_word,
	input  logic            q_full
);

	logic                        bg_valid_q;
	logic [bdk_pkg::SUM_W-1:0]   acc_q;

	logic                        valid_s1;
	logic [bdk_pkg::DIFF_W-1:0]  diff_s1;
	logic                        last_s1;
	logic                        first_s1;

	logic                        valid_s2;
	logic [bdk_pkg::DIFF_W-1:0]  diff_s2;
	logic                        last_s2;
	logic                        first_s2;
	logic [bdk_pkg::SUM_W-1:0]   sum_s2;

	logic                        accept;
	logic                        adv_s1;
	logic                        adv_s2;
	logic [bdk_pkg::DIFF_W-1:0]  diff_in;
	logic [bdk_pkg::SUM_W:0]     sum_add;
	logic [bdk_pkg::SUM_W-1:0]   sum_next;

	assign adv_s2    = valid_s2 && !q_full;
	assign adv_s1    = valid_s1 && (!valid_s2 || adv_s2);
	assign pix.ready = !valid_s1 || adv_s1;
	assign accept    = pix.valid && pix.ready;

	// no background before the first frame ends, so the difference counts as zero
	assign diff_in = bg_valid_q ?
		(bdk_pkg::DIFF_W'(bdk_pkg::absdiff(pix.cur_luma, pix.bg_luma))
		+ bdk_pkg::DIFF_W'(bdk_pkg::absdiff(pix.cur_cb, pix.bg_cb))
		+ bdk_pkg::DIFF_W'(bdk_pkg::absdiff(pix.cur_cr, pix.bg_cr)))
		: '0;

	assign sum_add  = {1'b0, acc_q} + (bdk_pkg::SUM_W + 1)'(diff_s1);
	assign sum_next = sum_add[bdk_pkg::SUM_W] ? '1 : sum_add[bdk_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_valid_q <= 1'b0;
			acc_q      <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (accept && pix.frame_last) begin
				bg_valid_q <= 1'b1;
			end
			if (pix.ready) begin
				valid_s1 <= pix.valid;
			end
			if (!valid_s2 || adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				acc_q <= last_s1 ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_s1  <= diff_in;
			last_s1  <= pix.frame_last;
			first_s1 <= !bg_valid_q;
		end
		if (adv_s1) begin
			diff_s2  <= diff_s1;
			last_s2  <= last_s1;
			first_s2 <= first_s1;
			sum_s2   <= sum_next;
		end
	end

	always_comb begin
		push                = adv_s2;
		push_word.diff      = diff_s2;
		push_word.last      = last_s2;
		push_word.replace   = last_s2 && (first_s2 || (sum_s2 > cfg.change_limit));
		push_word.frame_sum = last_s2 ? sum_s2 : '0;
	end

endmodule

[rtl/core/bdk_queue.sv]
// bdk_queue: short first-in first-out queue of classified words between front and back
// depends on bdk_pkg
module bdk_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bdk_pkg::work_t  push_word,
	output logic            full,
	input  logic            pop,
	output bdk_pkg::work_t  pop_word,
	output logic            not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bdk_pkg::work_t      mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

[rtl/core/bdk_back.sv]
// bdk_back: turns classified words into alpha, hard threshold or soft ramp, with output register
// depends on bdk_pkg and bdk_out_if
module bdk_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bdk_pkg::cfg_t   cfg,
	input  logic            q_not_empty,
	input  bdk_pkg::work_t  q_word,
	output logic            pop,
	bdk_out_if.source       key
);

	logic                          valid_s1;
	logic [bdk_pkg::PROD_W-1:0]    prod_s1;
	logic                          ge_s1;
	logic                          gt_s1;
	logic                          last_s1;
	logic                          replace_s1;
	logic [bdk_pkg::SUM_W-1:0]     sum_s1;

	logic                          valid_s2;
	logic [bdk_pkg::SAMPLE_W-1:0]  alpha_s2;
	logic                          last_s2;
	logic                          replace_s2;
	logic [bdk_pkg::SUM_W-1:0]     sum_s2;

	logic                          adv_s1;
	logic [bdk_pkg::DIFF_W-1:0]    delta;
	logic [bdk_pkg::RND_W-1:0]     rnd;
	logic [bdk_pkg::RAMP_W-1:0]    ramp;
	logic [bdk_pkg::SAMPLE_W-1:0]  ramp_clip;
	logic [bdk_pkg::SAMPLE_W-1:0]  alpha_next;

	assign adv_s1 = valid_s1 && (!valid_s2 || key.ready);
	assign pop    = q_not_empty && (!valid_s1 || adv_s1);
	assign delta  = cfg.match_limit - q_word.diff;

	// ceiling of the q.8 product, limited to the sample range
	assign rnd       = bdk_pkg::RND_W'(prod_s1) + bdk_pkg::RND_W'(255);
	assign ramp      = rnd[bdk_pkg::RND_W-1:8];
	assign ramp_clip = (ramp > bdk_pkg::RAMP_W'(cfg.sample_max)) ? cfg.sample_max
		: ramp[bdk_pkg::SAMPLE_W-1:0];

	always_comb begin
		if (cfg.blend_on) begin
			alpha_next = ge_s1 ? cfg.sample_max : (cfg.sample_max - ramp_clip);
		end else begin
			alpha_next = gt_s1 ? cfg.sample_max : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || adv_s1) begin
				valid_s1 <= q_not_empty;
			end
			if (!valid_s2 || key.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1    <= bdk_pkg::PROD_W'(delta) * bdk_pkg::PROD_W'(cfg.inv_blend);
			ge_s1      <= (q_word.diff >= cfg.match_limit);
			gt_s1      <= (q_word.diff > cfg.match_limit);
			last_s1    <= q_word.last;
			replace_s1 <= q_word.replace;
			sum_s1     <= q_word.frame_sum;
		end
		if (adv_s1) begin
			alpha_s2   <= alpha_next;
			last_s2    <= last_s1;
			replace_s2 <= replace_s1;
			sum_s2     <= sum_s1;
		end
	end

	assign key.valid              = valid_s2;
	assign key.alpha              = alpha_s2;
	assign key.frame_done         = last_s2;
	assign key.replace_background = replace_s2;
	assign key.frame_sum          = sum_s2;

endmodule

[rtl/core/background_difference_key.sv]
// background_difference_key: top level, register file, front, queue and back
// depends on bdk_pkg, bdk_in_if, bdk_out_if, bdk_front, bdk_queue, bdk_back
//
//   channel  direction  handshake        payload
//   pix      in         valid / ready    current and background samples, frame_last
//   key      out        valid / ready    alpha, frame_done, replace_background, frame_sum
//   cfg      in         cfg_we           cfg_idx, cfg_wdata
//
// one pixel per clock while key keeps taking words; a word taken at pix shows on key after
// the second front stage, the queue, the multiplier stage and the output register
// reset clears all control state and loads the register defaults, no clearing pass
// the front keeps taking words while the queue has room, so a stall on key
// reaches pix only after the queue of QUEUE_DEPTH words has filled
module background_difference_key #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	bdk_in_if.sink                             pix,
	bdk_out_if.source                          key,
	input  logic                               cfg_we,
	input  logic [bdk_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [bdk_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	bdk_pkg::cfg_t   cfg_q;
	logic            push;
	bdk_pkg::work_t  push_word;
	logic            q_full;
	logic            pop;
	bdk_pkg::work_t  pop_word;
	logic            q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bdk_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bdk_pkg::CFG_SAMPLE_MAX: begin
					cfg_q.sample_max <= cfg_wdata[bdk_pkg::SAMPLE_W-1:0];
				end
				bdk_pkg::CFG_MATCH_LIMIT: begin
					cfg_q.match_limit <= cfg_wdata[bdk_pkg::DIFF_W-1:0];
				end
				bdk_pkg::CFG_BLEND_ON: begin
					cfg_q.blend_on <= cfg_wdata[0];
				end
				bdk_pkg::CFG_INV_BLEND: begin
					cfg_q.inv_blend <= cfg_wdata[bdk_pkg::INV_W-1:0];
				end
				bdk_pkg::CFG_CHANGE_LIMIT: begin
					cfg_q.change_limit <= cfg_wdata[bdk_pkg::SUM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	bdk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix       (pix),
		.push      (push),
		.push_word (push_word),
		.q_full    (q_full)
	);

	bdk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (pop),
		.pop_word  (pop_word),
		.not_empty (q_not_empty)
	);

	bdk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_word      (pop_word),
		.pop         (pop),
		.key         (key)
	);

endmodule
